>>> rtl/bce_pkg.sv
// Shared types, constants and the symbol table of the base32 byte encoder.
`default_nettype none
package bce_pkg;

  // Widths of the raw byte, one 5-bit group and one output character
  localparam int unsigned ByteW    = 8;
  localparam int unsigned GroupW   = 5;
  localparam int unsigned CharW    = 8;
  localparam int unsigned LeftW    = 4;
  localparam int unsigned LeftCntW = 3;
  localparam int unsigned MaxChars = 3;

  // Default depth of the job queue between the front and the back
  localparam int unsigned QueueDepth = 2;

  // Symbol table, first symbol in the top byte
  localparam logic [32*CharW-1:0] AlphabetStr = "23456789abcdefghijkmnpqrstuvwxyz";

  // One accepted byte, broken into the characters it produces
  typedef struct packed {
    logic [MaxChars-1:0][GroupW-1:0] groups;     // group 0 goes out first
    logic [1:0]                      num_chars;  // 1 to 3
    logic                            last;       // job closes a message
  } job_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Map one 5-bit group to the ASCII code of its symbol
  function automatic logic [CharW-1:0] char_of(input logic [GroupW-1:0] grp);
    logic [GroupW-1:0] pos;
    pos = 5'd31 - grp;
    return AlphabetStr[{pos, 3'b000} +: CharW];
  endfunction

endpackage
`default_nettype wire

>>> rtl/bce_if.sv
// Valid/ready channel interfaces for raw bytes and encoded characters.
`default_nettype none
interface bce_byte_if;
  logic                     valid;
  logic                     ready;
  logic [bce_pkg::ByteW-1:0] data_byte;
  logic                     last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bce_char_if;
  logic                     valid;
  logic                     ready;
  logic [bce_pkg::CharW-1:0] out_char;
  logic                     last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

>>> rtl/bce_front.sv
// Front end: accepts bytes, merges them with leftover bits and forms jobs.
`default_nettype none
module bce_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bce_byte_if.sink           byte_i,
  input  bce_pkg::q_status_t q_status_i,
  output logic               push_o,
  output bce_pkg::job_t      job_o
);

  logic [bce_pkg::LeftW-1:0]    left_q, left_d;
  logic [bce_pkg::LeftCntW-1:0] cnt_q, cnt_d;

  logic [11:0] acc;
  logic [11:0] aligned;
  logic [14:0] padded;
  logic [3:0]  total;
  logic        two_full;
  logic [2:0]  rem;
  logic [4:0]  rem_mask;

  // Accept a request whenever the queue has room
  assign byte_i.ready = !q_status_i.full;
  assign push_o       = byte_i.valid && byte_i.ready;

  // Merge pending bits above the byte and left-align the valid bits
  always_comb begin
    acc      = {left_q, byte_i.data_byte};
    total    = 4'(cnt_q) + 4'd8;
    aligned  = acc << (3'd4 - cnt_q);
    padded   = {aligned, 3'b000};
    two_full = (total >= 4'd10);
    rem      = two_full ? 3'(total - 4'd10) : 3'(total - 4'd5);
    rem_mask = (5'd1 << rem) - 5'd1;

    job_o.groups[0] = padded[14:10];
    job_o.groups[1] = padded[9:5];
    job_o.groups[2] = padded[4:0];
    job_o.last      = byte_i.last_byte;
    if (two_full) begin
      job_o.num_chars = (byte_i.last_byte && rem != 3'd0) ? 2'd3 : 2'd2;
    end else begin
      job_o.num_chars = (byte_i.last_byte && rem != 3'd0) ? 2'd2 : 2'd1;
    end

    // Keep the remainder, or drop it at the end of a message
    left_d = left_q;
    cnt_d  = cnt_q;
    if (push_o) begin
      if (byte_i.last_byte) begin
        left_d = '0;
        cnt_d  = '0;
      end else begin
        left_d = byte_i.data_byte[3:0] & rem_mask[3:0];
        cnt_d  = rem;
      end
    end
  end

  // Hold leftover bits between requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      cnt_q  <= '0;
    end else begin
      left_q <= left_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bce_queue.sv
// Short job queue that decouples the front end from the character back end.
`default_nettype none
module bce_queue #(
  parameter int unsigned Depth = bce_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  bce_pkg::job_t       job_i,
  input  wire logic           pop_i,
  output bce_pkg::job_t       head_o,
  output bce_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bce_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // Advance pointers and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty))
    else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

>>> rtl/bce_back.sv
// Back end: walks the head job and sends one character per cycle while the sink is ready and a job waits.
`default_nettype none
module bce_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  bce_pkg::job_t      head_i,
  input  bce_pkg::q_status_t q_status_i,
  output logic               pop_o,
  bce_char_if.source         char_o
);

  logic                      valid_q, valid_d;
  logic [bce_pkg::CharW-1:0] char_q, char_d;
  logic                      last_q, last_d;
  logic [1:0]                idx_q, idx_d;
  logic                      load;
  logic                      final_of_job;

  assign char_o.valid     = valid_q;
  assign char_o.out_char  = char_q;
  assign char_o.last_char = last_q;

  // Refill the output register when it is empty or being taken and the queue holds a job
  always_comb begin
    load         = (!valid_q || char_o.ready) && !q_status_i.empty;
    final_of_job = (idx_q == head_i.num_chars - 2'd1);
    pop_o        = load && final_of_job;

    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    idx_d   = idx_q;
    if (char_o.ready) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      char_d  = bce_pkg::char_of(head_i.groups[idx_q]);
      last_d  = head_i.last && final_of_job;
      idx_d   = final_of_job ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

`ifndef SYNTH
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> (idx_q < head_i.num_chars))
    else $error("character index beyond job");
  a_idx_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0))
    else $error("index not cleared after job");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !char_o.ready) |=> (valid_q && $stable(char_q) && $stable(last_q)))
    else $error("character changed while stalled");
`endif

endmodule
`default_nettype wire

>>> rtl/base32_byte_encode.sv
// The first character of a byte passes the job queue, then the output register, before it is valid.
// The output register gives one character per cycle while the sink is ready; a byte yields 1 to 3
// characters (1.6 on average).
// A byte is taken each cycle while the job queue between front and back has room.
// Reset (asynchronous, active low) clears leftover bits, the queue and the output valid.
`default_nettype none
module base32_byte_encode #(
  parameter int unsigned QueueDepth = bce_pkg::QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bce_byte_if.sink   byte_i,
  bce_char_if.source char_o
);

  logic               push;
  logic               pop;
  bce_pkg::job_t      job;
  bce_pkg::job_t      head;
  bce_pkg::q_status_t q_status;

  // Classify bytes into jobs
  bce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job)
  );

  // Buffer jobs
  bce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Emit characters
  bce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .char_o     (char_o)
  );

endmodule
`default_nettype wire
